>>> rtl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types for the topic string validator: the request carried from the
// input register into the checking stage.
// ----------------------------------------------------------------------------
package tsv_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
		logic       filter_mode;
	} tsv_item_t;

endpackage

>>> rtl/tsv_in_stage.sv
// ----------------------------------------------------------------------------
// tsv_in_stage
// Input register. Holds one byte request until the checking stage takes it
// and stalls the sender only while a held request cannot move on.
// ----------------------------------------------------------------------------
module tsv_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  tsv_pkg::tsv_item_t item_in,
	input  logic               advance,
	output logic               item_valid_s1,
	output tsv_pkg::tsv_item_t item_s1
);
	import tsv_pkg::*;

	logic accept;

	assign byte_stall = item_valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule

>>> rtl/tsv_core.sv
// ----------------------------------------------------------------------------
// tsv_core
// Per-string state and the combinational checks: byte count, UTF-8 decode with
// code point screening, and the wildcard placement rules.
// ----------------------------------------------------------------------------
module tsv_core #(
	parameter int MAX_TOPIC = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid_s1,
	input  tsv_pkg::tsv_item_t item_s1,
	input  logic               out_free,
	output logic               advance,
	output logic               res_fire,
	output logic               res_ok
);
	import tsv_pkg::*;

	localparam int CNT_W = $clog2(MAX_TOPIC + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOPIC);

	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;

	function automatic logic code_bad(input logic [20:0] c, input logic [1:0] cls);
		logic [20:0] minimum;
		logic        bad;
		begin
			unique case (cls)
				2'd1:    minimum = 21'h80;
				2'd2:    minimum = 21'h800;
				2'd3:    minimum = 21'h10000;
				default: minimum = 21'h0;
			endcase
			bad = (c < minimum) || (c > 21'h10ffff);
			bad = bad || (c >= 21'hd800 && c <= 21'hdfff);
			bad = bad || (c < 21'h20) || (c >= 21'h7f && c <= 21'h9f);
			bad = bad || (c >= 21'hfdd0 && c <= 21'hfdef);
			bad = bad || (&c[15:1]);
			code_bad = bad;
		end
	endfunction

	logic             at_start_q;
	logic             filter_latched_q;
	logic [CNT_W-1:0] byte_count_q;
	logic             failed_q;
	logic [1:0]       bytes_owed_q;
	logic [20:0]      code_accum_q;
	logic [1:0]       length_class_q;
	logic             prev_was_slash_q;
	logic             plus_pending_q;

	logic             filt_n;
	logic [CNT_W-1:0] cnt_n;
	logic             fail_n;
	logic [1:0]       owed_n;
	logic [20:0]      accum_n;
	logic [1:0]       cls_n;
	logic             pws_c;
	logic             pp_c;
	logic [7:0]       b;
	logic             fin;

	assign b        = item_s1.text_byte;
	assign fin      = item_s1.final_byte;
	assign advance  = item_valid_s1 && (!fin || out_free);
	assign res_fire = advance && fin;
	assign res_ok   = !fail_n;

	always_comb begin
		// a new string starts from the cleared state
		filt_n  = at_start_q ? item_s1.filter_mode : filter_latched_q;
		cnt_n   = at_start_q ? '0 : byte_count_q;
		fail_n  = at_start_q ? 1'b0 : failed_q;
		owed_n  = at_start_q ? 2'd0 : bytes_owed_q;
		accum_n = at_start_q ? 21'd0 : code_accum_q;
		cls_n   = at_start_q ? 2'd0 : length_class_q;
		pws_c   = at_start_q ? 1'b1 : prev_was_slash_q;
		pp_c    = at_start_q ? 1'b0 : plus_pending_q;

		if (cnt_n <= CNT_MAX) begin
			cnt_n = cnt_n + 1'b1;
		end
		if (cnt_n > CNT_MAX) begin
			fail_n = 1'b1;
		end

		if (owed_n == 2'd0) begin
			if (b >= 8'hc2 && b <= 8'hdf) begin
				accum_n = {16'd0, b[4:0]};
				owed_n  = 2'd1;
				cls_n   = 2'd1;
			end else if (b >= 8'he0 && b <= 8'hef) begin
				accum_n = {17'd0, b[3:0]};
				owed_n  = 2'd2;
				cls_n   = 2'd2;
			end else if (b >= 8'hf0 && b <= 8'hf4) begin
				accum_n = {18'd0, b[2:0]};
				owed_n  = 2'd3;
				cls_n   = 2'd3;
			end else if (b[7]) begin
				fail_n = 1'b1;
			end else begin
				cls_n = 2'd0;
				if (code_bad({13'd0, b}, 2'd0)) begin
					fail_n = 1'b1;
				end
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				fail_n = 1'b1;
			end
			accum_n = {accum_n[14:0], b[5:0]};
			owed_n  = owed_n - 2'd1;
			if (owed_n == 2'd0 && code_bad(accum_n, cls_n)) begin
				fail_n = 1'b1;
			end
		end
		if (fin && owed_n != 2'd0) begin
			fail_n = 1'b1;
		end

		// wildcard placement
		if (pp_c && b != CH_SLASH) begin
			fail_n = 1'b1;
		end
		pp_c = 1'b0;
		if (b == CH_HASH) begin
			if (!filt_n || !fin || !pws_c) begin
				fail_n = 1'b1;
			end
		end else if (b == CH_PLUS) begin
			if (!filt_n || !pws_c) begin
				fail_n = 1'b1;
			end
			pp_c = 1'b1;
		end
		pws_c = (b == CH_SLASH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q       <= 1'b1;
			filter_latched_q <= 1'b0;
			byte_count_q     <= '0;
			failed_q         <= 1'b0;
			bytes_owed_q     <= 2'd0;
			code_accum_q     <= 21'd0;
			length_class_q   <= 2'd0;
			prev_was_slash_q <= 1'b1;
			plus_pending_q   <= 1'b0;
		end else if (advance) begin
			at_start_q       <= fin;
			filter_latched_q <= filt_n;
			byte_count_q     <= cnt_n;
			failed_q         <= fail_n;
			bytes_owed_q     <= owed_n;
			code_accum_q     <= accum_n;
			length_class_q   <= cls_n;
			prev_was_slash_q <= pws_c;
			plus_pending_q   <= pp_c;
		end
	end

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_MAX + 1'b1)
		else $error("byte count past saturation");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> at_start_q)
		else $error("string not restarted after its result");

	a_owed_cls: assert property (@(posedge clk) disable iff (!arst_n)
		(!at_start_q && bytes_owed_q != 2'd0) |-> (length_class_q >= bytes_owed_q))
		else $error("more continuation bytes owed than the sequence length");

	a_plus_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(!at_start_q && plus_pending_q) |-> (filter_latched_q || failed_q))
		else $error("plus wildcard accepted outside filter mode");

	a_no_fire_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> out_free)
		else $error("result issued while output register is full");

endmodule

>>> rtl/tsv_out_stage.sv
// ----------------------------------------------------------------------------
// tsv_out_stage
// Result register. Holds the verdict of one string until the receiver takes
// it; free again in the cycle it is taken.
// ----------------------------------------------------------------------------
module tsv_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic res_fire,
	input  logic res_ok,
	output logic out_free,
	output logic result_valid,
	input  logic result_stall,
	output logic string_ok
);
	import tsv_pkg::*;

	logic result_valid_q;
	logic string_ok_q;

	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign string_ok    = string_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			string_ok_q <= res_ok;
		end
	end

endmodule

>>> rtl/topic_string_validator.sv
// ----------------------------------------------------------------------------
// topic_string_validator
// Checks a topic name or topic filter fed one byte per request.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle with no gaps between strings unless stalled. A
// byte sits in the input register while the check stage updates the string
// state; the verdict shows on result_valid from the result register, loaded as
// the final byte leaves the input register. The state loop in the check stage
// sets the rate. Bytes that are not final produce no result and keep flowing
// while a verdict waits in the result register; only a final byte waits for
// that register to empty. filter_mode is taken from each string's first byte.
// ----------------------------------------------------------------------------
module topic_string_validator #(
	parameter int MAX_TOPIC = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	input  logic       filter_mode,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       string_ok
);
	import tsv_pkg::*;

	tsv_item_t item_in;
	tsv_item_t item_s1;
	logic      item_valid_s1;
	logic      advance;
	logic      out_free;
	logic      res_fire;
	logic      res_ok;

	assign item_in = '{text_byte: text_byte, final_byte: final_byte,
		filter_mode: filter_mode};

	tsv_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.item_in       (item_in),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	tsv_core #(
		.MAX_TOPIC (MAX_TOPIC)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.out_free      (out_free),
		.advance       (advance),
		.res_fire      (res_fire),
		.res_ok        (res_ok)
	);

	tsv_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_fire     (res_fire),
		.res_ok       (res_ok),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.string_ok    (string_ok)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the topic string validator.
// ----------------------------------------------------------------------------
// A directed set of short strings covers the wildcard rules, stray, truncated
// and overlong UTF-8, surrogates and out-of-range code points. Random strings
// follow: mostly well-formed topic names and filters, some of them corrupted,
// some pure noise, plus a string at the length limit and one a byte over it.
// A predictor tracks the per-string state and queues the verdict that each
// final byte should produce. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import tsv_pkg::*;

	localparam int TOPIC_MAX     = 256;
	localparam int RANDOM_TARGET = 700;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PRINT_CAP     = 50;

	localparam logic [7:0] SLASH    = 8'h2f;
	localparam logic [7:0] HASH     = 8'h23;
	localparam logic [7:0] PLUS     = 8'h2b;
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;

	localparam logic [20:0] CP_MAX     = 21'h10ffff;
	localparam logic [20:0] SURR_LO    = 21'h00d800;
	localparam logic [20:0] SURR_HI    = 21'h00dfff;
	localparam logic [20:0] NONCHAR_LO = 21'h00fdd0;
	localparam logic [20:0] NONCHAR_HI = 21'h00fdef;
	localparam logic [15:0] PLANE_TAIL = 16'hfffe;
	localparam logic [20:0] CTRL_END   = 21'h000020;
	localparam logic [20:0] DEL_LO     = 21'h00007f;
	localparam logic [20:0] C1_HI      = 21'h00009f;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       byte_valid   = 1'b0;
	logic       byte_stall;
	logic [7:0] text_byte    = 8'h00;
	logic       final_byte   = 1'b0;
	logic       filter_mode  = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       string_ok;

	topic_string_validator #(
		.MAX_TOPIC(TOPIC_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.filter_mode(filter_mode),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.string_ok(string_ok)
	);

	always #1 clk = ~clk;

	tsv_item_t  pending_bytes[$];
	logic [7:0] topic_text[$];
	logic [7:0] spill[$];
	logic       verdicts_due[$];

	int mismatches   = 0;
	int bytes_queued = 0;
	int bytes_taken  = 0;
	int strings_sent = 0;
	int verdicts_ok  = 0;
	int verdicts_bad = 0;

	// per-string state of the predictor
	logic       fresh_string  = 1'b1;
	logic       filt_q        = 1'b0;
	logic [8:0] count_q       = '0;
	logic       bad_q         = 1'b0;
	logic [1:0] owed_q        = '0;
	logic [20:0] cp_q         = '0;
	logic [1:0] cls_q         = '0;
	logic       after_slash_q = 1'b1;
	logic       after_plus_q  = 1'b0;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic cp_illegal(input logic [20:0] c, input logic [1:0] cls);
		logic [20:0] least;
		case (cls)
			2'd1: least = 21'h80;
			2'd2: least = 21'h800;
			2'd3: least = 21'h10000;
			default: least = 21'h0;
		endcase
		return c < least || c > CP_MAX || (c >= SURR_LO && c <= SURR_HI) ||
			c < CTRL_END || (c >= DEL_LO && c <= C1_HI) ||
			(c >= NONCHAR_LO && c <= NONCHAR_HI) || c[15:0] >= PLANE_TAIL;
	endfunction

	task automatic judge_topic_byte(input tsv_item_t it);
		logic [7:0] b;
		logic       fin;
		b = it.text_byte;
		fin = it.final_byte;
		if (fresh_string) begin
			filt_q = it.filter_mode;
			count_q = '0;
			bad_q = 1'b0;
			owed_q = '0;
			cp_q = '0;
			cls_q = '0;
			after_slash_q = 1'b1;
			after_plus_q = 1'b0;
			fresh_string = 1'b0;
		end
		if (count_q <= TOPIC_MAX)
			count_q++;
		if (count_q > TOPIC_MAX)
			bad_q = 1'b1;

		if (owed_q == 2'd0) begin
			if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				cp_q = {16'b0, b[4:0]};
				owed_q = 2'd1;
				cls_q = 2'd1;
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				cp_q = {17'b0, b[3:0]};
				owed_q = 2'd2;
				cls_q = 2'd2;
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				cp_q = {18'b0, b[2:0]};
				owed_q = 2'd3;
				cls_q = 2'd3;
			end else if (b[7]) begin
				bad_q = 1'b1;
			end else begin
				cls_q = 2'd0;
				if (cp_illegal({13'b0, b}, 2'd0))
					bad_q = 1'b1;
			end
		end else begin
			if (b[7:6] != 2'b10)
				bad_q = 1'b1;
			cp_q = {cp_q[14:0], b[5:0]};
			owed_q--;
			if (owed_q == 2'd0 && cp_illegal(cp_q, cls_q))
				bad_q = 1'b1;
		end
		if (fin && owed_q != 2'd0)
			bad_q = 1'b1;

		if (after_plus_q && b != SLASH)
			bad_q = 1'b1;
		after_plus_q = 1'b0;
		if (b == HASH) begin
			if (!filt_q || !fin || !after_slash_q)
				bad_q = 1'b1;
		end else if (b == PLUS) begin
			if (!filt_q || !after_slash_q)
				bad_q = 1'b1;
			after_plus_q = 1'b1;
		end
		after_slash_q = (b == SLASH);

		if (fin) begin
			verdicts_due.push_back(!bad_q);
			fresh_string = 1'b1;
		end
	endtask

	// turns topic_text into requests; filter_mode only matters on the first byte
	task automatic queue_topic(input logic filt);
		tsv_item_t it;
		for (int i = 0; i < topic_text.size(); i++) begin
			it.text_byte = topic_text[i];
			it.final_byte = (i == topic_text.size() - 1);
			it.filter_mode = (i == 0) ? filt : 1'($urandom_range(0, 1));
			pending_bytes.push_back(it);
			bytes_queued++;
		end
		strings_sent++;
		topic_text.delete();
	endtask

	task automatic push_topic(input logic filt, input int n, input logic [31:0] seq);
		for (int k = 0; k < n; k++)
			topic_text.push_back(seq[31 - 8 * k -: 8]);
		queue_topic(filt);
	endtask

	task automatic put_code(input logic [20:0] c, input int n);
		case (n)
			1: topic_text.push_back(c[7:0]);
			2: begin
				topic_text.push_back({3'b110, c[10:6]});
				topic_text.push_back({2'b10, c[5:0]});
			end
			3: begin
				topic_text.push_back({4'b1110, c[15:12]});
				topic_text.push_back({2'b10, c[11:6]});
				topic_text.push_back({2'b10, c[5:0]});
			end
			default: begin
				topic_text.push_back({5'b11110, c[20:18]});
				topic_text.push_back({2'b10, c[17:12]});
				topic_text.push_back({2'b10, c[11:6]});
				topic_text.push_back({2'b10, c[5:0]});
			end
		endcase
	endtask

	task automatic put_valid_char();
		logic [20:0] c;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			do c = 21'($urandom_range(32'h20, 32'h7e));
			while (c[7:0] == HASH || c[7:0] == PLUS || c[7:0] == SLASH);
			put_code(c, 1);
		end else if (pick < 75) begin
			put_code(21'($urandom_range(32'ha0, 32'h7ff)), 2);
		end else if (pick < 90) begin
			do c = 21'($urandom_range(32'h800, 32'hfffd));
			while ((c >= SURR_LO && c <= SURR_HI) || (c >= NONCHAR_LO && c <= NONCHAR_HI));
			put_code(c, 3);
		end else begin
			do c = 21'($urandom_range(32'h10000, 32'h10ffff));
			while (c[15:0] >= PLANE_TAIL);
			put_code(c, 4);
		end
	endtask

	// boundary or arbitrary code point, sometimes in an overlong form
	task automatic put_odd_char();
		logic [20:0] c;
		int          len;
		case ($urandom_range(0, 25))
			0: c = 21'h0;
			1: c = 21'h1f;
			2: c = 21'h20;
			3: c = 21'h7e;
			4: c = 21'h7f;
			5: c = 21'h9f;
			6: c = 21'ha0;
			7: c = 21'h7ff;
			8: c = 21'h800;
			9: c = 21'hd7ff;
			10: c = 21'hd800;
			11: c = 21'hdfff;
			12: c = 21'he000;
			13: c = 21'hfdcf;
			14: c = 21'hfdd0;
			15: c = 21'hfdef;
			16: c = 21'hfdf0;
			17: c = 21'hfffd;
			18: c = 21'hfffe;
			19: c = 21'hffff;
			20: c = 21'h10000;
			21: c = 21'h1fffe;
			22: c = 21'h10ffff;
			23: c = 21'h110000;
			24: c = 21'h1fffff;
			default: c = 21'($urandom_range(0, 32'h1fffff));
		endcase
		len = (c < 21'h80) ? 1 : (c < 21'h800) ? 2 : (c < 21'h10000) ? 3 : 4;
		if ($urandom_range(0, 3) == 0)
			len = $urandom_range(len, 4);
		put_code(c, len);
	endtask

	task automatic make_topic(output logic filt);
		int         levels;
		int         pick;
		int         pos;
		filt = 1'($urandom_range(0, 1));
		levels = $urandom_range(1, 4);
		for (int lv = 0; lv < levels; lv++) begin
			if (lv != 0)
				topic_text.push_back(SLASH);
			pick = $urandom_range(0, 9);
			if (pick == 0 && filt)
				topic_text.push_back(PLUS);
			else if (pick != 1)
				repeat ($urandom_range(1, 3)) put_valid_char();
		end
		if (filt && $urandom_range(0, 3) == 0) begin
			topic_text.push_back(SLASH);
			topic_text.push_back(HASH);
		end
		if ($urandom_range(0, 2) == 0) begin
			pick = $urandom_range(0, 4);
			if (pick == 0) begin
				if (topic_text.size() > 1)
					void'(topic_text.pop_back());
			end else if (pick == 1) begin
				filt = ~filt;
			end else begin
				pos = $urandom_range(0, topic_text.size());
				while (topic_text.size() > pos)
					spill.push_front(topic_text.pop_back());
				case (pick)
					2: put_odd_char();
					3: topic_text.push_back(8'($urandom_range(0, 255)));
					default: topic_text.push_back($urandom_range(0, 1) ? PLUS : HASH);
				endcase
				while (spill.size() != 0)
					topic_text.push_back(spill.pop_front());
			end
		end
		if (topic_text.size() == 0)
			topic_text.push_back(8'h61);
	endtask

	task automatic make_long_topic(input int len);
		for (int i = 0; i < len; i++)
			topic_text.push_back(($urandom_range(0, 15) == 0) ? SLASH :
				8'($urandom_range(32'h61, 32'h7a)));
		queue_topic(1'($urandom_range(0, 1)));
	endtask

	// request driver: bursts of random length with random gaps
	int        gap_left   = 0;
	int        burst_left = 0;
	tsv_item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			text_byte <= 8'h00;
			final_byte <= 1'b0;
			filter_mode <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else if (!byte_valid || !byte_stall) begin
			if (gap_left != 0 || pending_bytes.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				byte_valid <= 1'b0;
			end else begin
				next_item = pending_bytes.pop_front();
				text_byte <= next_item.text_byte;
				final_byte <= next_item.final_byte;
				filter_mode <= next_item.filter_mode;
				byte_valid <= 1'b1;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// result stall: style changes every so often, one style never stalls
	int   stall_style = 0;
	int   style_left  = 0;
	int   run_left    = 0;
	logic stall_run   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(50, 300);
				run_left = 0;
			end else begin
				style_left--;
			end
			if (run_left == 0) begin
				case (stall_style)
					0: stall_run = 1'b0;
					1: stall_run = ($urandom_range(0, 1) == 1);
					2: stall_run = ($urandom_range(0, 2) != 0);
					default: stall_run = ~stall_run;
				endcase
				run_left = (stall_style == 2) ? $urandom_range(1, 20) : $urandom_range(1, 3);
			end else begin
				run_left--;
			end
			result_stall <= stall_run;
		end
	end

	// monitor: results are checked before the same edge's request is predicted
	logic exp_ok;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("result with none pending, string_ok=%0b",
						string_ok));
				end else begin
					exp_ok = verdicts_due.pop_front();
					if (string_ok !== exp_ok)
						report_mismatch($sformatf("string_ok=%0b, predicted %0b",
							string_ok, exp_ok));
					if (exp_ok)
						verdicts_ok++;
					else
						verdicts_bad++;
				end
			end
			if (byte_valid && !byte_stall) begin
				judge_topic_byte('{text_byte: text_byte, final_byte: final_byte,
					filter_mode: filter_mode});
				bytes_taken++;
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int   start_bytes;
		logic filt;
		logic did_full;
		logic did_over;

		did_full = 1'b0;
		did_over = 1'b0;

		push_topic(1'b0, 1, {8'h61, 24'h0});
		push_topic(1'b0, 1, {8'h00, 24'h0});
		push_topic(1'b1, 1, {8'hff, 24'h0});
		push_topic(1'b0, 1, {8'h7f, 24'h0});
		push_topic(1'b1, 1, {HASH, 24'h0});
		push_topic(1'b0, 1, {HASH, 24'h0});
		push_topic(1'b1, 1, {PLUS, 24'h0});
		push_topic(1'b1, 2, {8'h61, PLUS, 16'h0});
		push_topic(1'b1, 2, {PLUS, 8'h61, 16'h0});
		push_topic(1'b1, 2, {HASH, SLASH, 16'h0});
		// truncated, bad continuation, overlong, surrogate, above the code space
		push_topic(1'b0, 1, {8'hc3, 24'h0});
		push_topic(1'b0, 2, {8'hc3, 8'h41, 16'h0});
		push_topic(1'b0, 2, {8'hc0, 8'h80, 16'h0});
		push_topic(1'b0, 3, {8'hed, 8'ha0, 8'h80, 8'h0});
		push_topic(1'b0, 4, {8'hf4, 8'h90, 8'h80, 8'h80});

		start_bytes = bytes_queued;
		while (bytes_queued - start_bytes < RANDOM_TARGET) begin
			if (!did_full && bytes_queued - start_bytes >= 200) begin
				make_long_topic(TOPIC_MAX);
				did_full = 1'b1;
			end else if (!did_over && bytes_queued - start_bytes >= 450) begin
				make_long_topic(TOPIC_MAX + 1);
				did_over = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					topic_text.push_back(8'($urandom_range(0, 255)));
				queue_topic(1'($urandom_range(0, 1)));
			end else begin
				make_topic(filt);
				queue_topic(filt);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < bytes_queued || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d strings in %0d bytes, including strings of %0d and %0d bytes",
			strings_sent, bytes_queued, TOPIC_MAX, TOPIC_MAX + 1);
		$display("verdicts checked: %0d valid, %0d rejected", verdicts_ok, verdicts_bad);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
